/* sv/kvt_pkg.sv */
// Package for the key/value text to record encoder.
// Types, codes and constants shared by the controller, datapath and top level.
// No dependencies.
`default_nettype none

package kvt_pkg;

    // Input item kinds; kind 3 carries no meaning and is ignored
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY_KEY = 3'd1;
    localparam logic [2:0] ST_KEY_LONG  = 3'd2;
    localparam logic [2:0] ST_NO_SEP    = 3'd3;
    localparam logic [2:0] ST_VAL_LONG  = 3'd4;

    // Characters
    localparam logic [7:0] CH_BLANK_MAX = 8'h20;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_EQUAL     = 8'h3D;
    localparam logic [7:0] CH_COLON     = 8'h3A;

    // Header bytes 00 50 4D FF, lane 0 in the low byte
    localparam logic [31:0] MAGIC_WORD   = 32'hFF4D5000;
    localparam logic [4:0]  MAGIC_BYTES  = 5'd4;

    // Field stores and output packing
    localparam int          STORE_DEPTH  = 256;
    localparam int          STORE_AW     = 8;
    localparam int          LANES        = 16;
    localparam logic [15:0] SHOWN_MAX    = 16'hFFFF;

    // Line parse phase
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LINE,
        PH_COMMENT,
        PH_KEY,
        PH_VLEAD,
        PH_VALUE
    } t_phase;

    // What an accepted input item does
    typedef enum logic [2:0] {
        EV_NONE,
        EV_BYTE,
        EV_SKIP,
        EV_START,
        EV_ERROR,
        EV_RECORD
    } t_event;

    // Section of the record being read out
    typedef enum logic [2:0] {
        SEC_KLEN,
        SEC_VLEN,
        SEC_KEY,
        SEC_VAL,
        SEC_TERM
    } t_sec;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_FETCH,
        S_PACK,
        S_PUSH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic take;   // input transaction this cycle
        logic one;    // load the single header or error item
        logic pack;   // pack the fetched record byte
        logic push;   // load the packed item into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_event ev;       // classification of the offered input item
        logic   out_free; // output register can take an item
        logic   pk_last;  // byte in hand is the last one of the record
        logic   pk_full;  // byte in hand fills the last lane
        logic   done;     // record fully packed
    } t_stat;

endpackage

`default_nettype wire

/* sv/kvt_in_if.sv */
// Input channel: valid/ready handshake with kind and text byte.
// No dependencies.
`default_nettype none

interface kvt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] text_byte;

    modport source (output valid, output kind, output text_byte, input ready);
    modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

`default_nettype wire

/* sv/kvt_out_if.sv */
// Output channel: valid/ready handshake with one 16-byte result item.
// No dependencies.
`default_nettype none

interface kvt_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_low;
    logic [63:0] data_high;
    logic [4:0]  byte_count;
    logic        last;
    logic [2:0]  status;
    logic [15:0] line_number;

    modport source (output valid, output data_low, output data_high, output byte_count,
                    output last, output status, output line_number, input ready);
    modport sink   (input valid, input data_low, input data_high, input byte_count,
                    input last, input status, input line_number, output ready);
endinterface

`default_nettype wire

/* sv/kvt_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module kvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

/* sv/kvt_ctrl.sv */
// Controller state machine: input handshake and sequencing of result items.
// Depends on kvt_pkg.
`default_nettype none

module kvt_ctrl
    import kvt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.ev == EV_START || i_stat.ev == EV_ERROR) begin
                        n_state = S_ONE;
                    end else if (i_stat.ev == EV_RECORD) begin
                        n_state = S_FETCH;
                    end
                end
            end
            S_ONE: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: begin
                n_state = S_PACK;
            end
            S_PACK: begin
                if (i_stat.pk_last || i_stat.pk_full) begin
                    n_state = S_PUSH;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.done ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_ONE: begin
                o_cmd.one = i_stat.out_free;
            end
            S_PACK: begin
                o_cmd.pack = 1'b1;
            end
            S_PUSH: begin
                o_cmd.push = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/kvt_dp.sv */
// Datapath: line parsing, key and value stores, record packing, output register.
// Depends on kvt_pkg and kvt_ram.
`default_nettype none

module kvt_dp
    import kvt_pkg::*;
#(
    parameter int MAX_FIELD_LEN   = 255,
    parameter int LINE_COUNT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_text_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_data_low,
    output logic [63:0]      o_data_high,
    output logic [4:0]       o_byte_count,
    output logic             o_last,
    output logic [2:0]       o_status,
    output logic [15:0]      o_line_number
);

    localparam logic [8:0] MAX_LEN = 9'(MAX_FIELD_LEN);
    localparam logic [8:0] OVF_LEN = 9'(MAX_FIELD_LEN + 1);

    // Line state
    t_phase                     r_phase, n_phase;
    logic [8:0]                 r_kcount, n_kcount;
    logic [8:0]                 r_kpend, n_kpend;
    logic [8:0]                 r_vcount, n_vcount;
    logic [8:0]                 r_vpend, n_vpend;
    logic [1:0]                 r_ovf, n_ovf;
    logic [LINE_COUNT_BITS-1:0] r_line, n_line;
    logic [2:0]                 r_one_status, n_one_status;

    // Record readout
    logic                       r_term, n_term;
    t_sec                       r_sec, n_sec;
    logic [8:0]                 r_idx, n_idx;
    logic                       r_done, n_done;
    logic [LANES-1:0][7:0]      r_pack, n_pack;
    logic [4:0]                 r_fill, n_fill;

    // Output register
    logic                       r_ov;
    logic [127:0]               r_odata;
    logic [4:0]                 r_ocount;
    logic                       r_olast;
    logic [2:0]                 r_ostatus;
    logic [15:0]                r_oline;

    logic [2:0]                 w_fin_st;
    logic                       w_fin_skip;
    t_event                     w_ev;
    logic                       w_blank;
    logic                       w_sep;
    logic                       w_is_val;
    logic [8:0]                 w_pos;
    logic                       w_room;
    logic                       w_add;
    logic                       w_wr_key;
    logic                       w_wr_val;
    logic [7:0]                 w_key_rd;
    logic [7:0]                 w_val_rd;
    logic [7:0]                 w_byte;
    logic                       w_pk_last;
    logic [8:0]                 w_idx_inc;
    logic [31:0]                w_line_ext;
    logic [15:0]                w_shown;
    logic                       w_out_free;

    // Field stores
    kvt_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_key),
        .i_wr_addr (w_pos[STORE_AW-1:0]),
        .i_wr_data (i_text_byte),
        .i_rd_addr (r_idx[STORE_AW-1:0]),
        .o_rd_data (w_key_rd)
    );

    kvt_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_val_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_val),
        .i_wr_addr (w_pos[STORE_AW-1:0]),
        .i_wr_data (i_text_byte),
        .i_rd_addr (r_idx[STORE_AW-1:0]),
        .o_rd_data (w_val_rd)
    );

    // Line end outcome: status, or skip for blank and comment lines
    always_comb begin
        w_fin_st   = ST_OK;
        w_fin_skip = 1'b0;
        case (r_phase)
            PH_KEY: begin
                w_fin_st = r_ovf[0] ? ST_KEY_LONG : ST_NO_SEP;
            end
            PH_VLEAD, PH_VALUE: begin
                if (r_kcount == 9'd0) begin
                    w_fin_st = ST_EMPTY_KEY;
                end else if (r_ovf[0]) begin
                    w_fin_st = ST_KEY_LONG;
                end else if (r_ovf[1]) begin
                    w_fin_st = ST_VAL_LONG;
                end
            end
            default: begin
                w_fin_skip = 1'b1;
            end
        endcase
    end

    // Classify the offered input item
    always_comb begin
        w_ev = EV_NONE;
        if (i_kind == KIND_START) begin
            w_ev = EV_START;
        end else if (r_phase != PH_IDLE && i_kind == KIND_END) begin
            w_ev = (w_fin_st != ST_OK) ? EV_ERROR : EV_RECORD;
        end else if (r_phase != PH_IDLE && i_kind == KIND_BYTE) begin
            if (i_text_byte == CH_NEWLINE) begin
                if (w_fin_st != ST_OK) begin
                    w_ev = EV_ERROR;
                end else begin
                    w_ev = w_fin_skip ? EV_SKIP : EV_RECORD;
                end
            end else begin
                w_ev = EV_BYTE;
            end
        end
    end

    // Field append: trailing blanks held pending until a non-blank arrives
    assign w_blank  = (i_text_byte <= CH_BLANK_MAX);
    assign w_sep    = (i_text_byte == CH_EQUAL) || (i_text_byte == CH_COLON);
    assign w_is_val = (r_phase == PH_VLEAD) || (r_phase == PH_VALUE);
    assign w_pos    = w_is_val ? (r_vcount + r_vpend) : (r_kcount + r_kpend);
    assign w_room   = (w_pos < MAX_LEN);

    always_comb begin
        w_add = 1'b0;
        case (r_phase)
            PH_LINE:  w_add = !w_blank && (i_text_byte != CH_HASH) && !w_sep;
            PH_KEY:   w_add = !w_sep;
            PH_VLEAD: w_add = !w_blank;
            PH_VALUE: w_add = 1'b1;
            default:  w_add = 1'b0;
        endcase
    end

    assign w_wr_key = i_cmd.take && (w_ev == EV_BYTE) && w_add && !w_is_val && w_room;
    assign w_wr_val = i_cmd.take && (w_ev == EV_BYTE) && w_add && w_is_val && w_room;

    // Line state update
    always_comb begin
        n_phase      = r_phase;
        n_kcount     = r_kcount;
        n_kpend      = r_kpend;
        n_vcount     = r_vcount;
        n_vpend      = r_vpend;
        n_ovf        = r_ovf;
        n_line       = r_line;
        n_one_status = r_one_status;
        if (i_cmd.take) begin
            case (w_ev)
                EV_START: begin
                    n_kcount     = '0;
                    n_kpend      = '0;
                    n_vcount     = '0;
                    n_vpend      = '0;
                    n_ovf        = '0;
                    n_line       = LINE_COUNT_BITS'(1);
                    n_phase      = PH_LINE;
                    n_one_status = ST_OK;
                end
                EV_ERROR: begin
                    n_one_status = w_fin_st;
                    n_phase      = PH_IDLE;
                end
                EV_SKIP: begin
                    n_kcount = '0;
                    n_kpend  = '0;
                    n_vcount = '0;
                    n_vpend  = '0;
                    n_ovf    = '0;
                    n_phase  = PH_LINE;
                    if (r_line != '1) begin
                        n_line = r_line + LINE_COUNT_BITS'(1);
                    end
                end
                EV_BYTE: begin
                    // phase moves
                    case (r_phase)
                        PH_LINE: begin
                            if (!w_blank) begin
                                if (i_text_byte == CH_HASH) begin
                                    n_phase = PH_COMMENT;
                                end else if (w_sep) begin
                                    n_phase = PH_VLEAD;
                                end else begin
                                    n_phase = PH_KEY;
                                end
                            end
                        end
                        PH_KEY: begin
                            if (w_sep) begin
                                n_kpend = '0;
                                n_phase = PH_VLEAD;
                            end
                        end
                        PH_VLEAD: begin
                            if (!w_blank) begin
                                n_phase = PH_VALUE;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                    // count and pending blank updates
                    if (w_add) begin
                        if (w_blank) begin
                            if (w_room) begin
                                if (w_is_val) n_vpend = r_vpend + 9'd1;
                                else          n_kpend = r_kpend + 9'd1;
                            end
                        end else if (w_is_val) begin
                            n_vpend  = '0;
                            n_vcount = w_room ? (w_pos + 9'd1) : OVF_LEN;
                            if (!w_room) n_ovf[1] = 1'b1;
                        end else begin
                            n_kpend  = '0;
                            n_kcount = w_room ? (w_pos + 9'd1) : OVF_LEN;
                            if (!w_room) n_ovf[0] = 1'b1;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end else if (i_cmd.push && r_done) begin
            // record fully delivered: close the line
            if (r_term) begin
                n_phase = PH_IDLE;
            end else begin
                n_kcount = '0;
                n_kpend  = '0;
                n_vcount = '0;
                n_vpend  = '0;
                n_ovf    = '0;
                n_phase  = PH_LINE;
                if (r_line != '1) begin
                    n_line = r_line + LINE_COUNT_BITS'(1);
                end
            end
        end
    end

    // Current record byte
    always_comb begin
        case (r_sec)
            SEC_KLEN: w_byte = r_kcount[7:0];
            SEC_VLEN: w_byte = r_vcount[7:0];
            SEC_KEY:  w_byte = w_key_rd;
            SEC_VAL:  w_byte = w_val_rd;
            default:  w_byte = 8'h00;
        endcase
    end

    assign w_idx_inc = r_idx + 9'd1;

    always_comb begin
        case (r_sec)
            SEC_VLEN: w_pk_last = (r_kcount == 9'd0) && (r_vcount == 9'd0) && !r_term;
            SEC_KEY:  w_pk_last = (w_idx_inc == r_kcount) && (r_vcount == 9'd0) && !r_term;
            SEC_VAL:  w_pk_last = (w_idx_inc == r_vcount) && !r_term;
            SEC_TERM: w_pk_last = 1'b1;
            default:  w_pk_last = 1'b0;
        endcase
    end

    // Record readout and lane packing
    always_comb begin
        n_term = r_term;
        n_sec  = r_sec;
        n_idx  = r_idx;
        n_done = r_done;
        n_pack = r_pack;
        n_fill = r_fill;
        if (i_cmd.take && w_ev == EV_RECORD) begin
            n_term = (i_kind == KIND_END);
            n_sec  = w_fin_skip ? SEC_TERM : SEC_KLEN;
            n_idx  = '0;
            n_done = 1'b0;
            n_pack = '0;
            n_fill = '0;
        end else if (i_cmd.pack) begin
            n_pack[r_fill[3:0]] = w_byte;
            n_fill = r_fill + 5'd1;
            n_done = w_pk_last;
            case (r_sec)
                SEC_KLEN: begin
                    n_sec = SEC_VLEN;
                end
                SEC_VLEN: begin
                    n_idx = '0;
                    if (r_kcount != 9'd0)      n_sec = SEC_KEY;
                    else if (r_vcount != 9'd0) n_sec = SEC_VAL;
                    else                       n_sec = SEC_TERM;
                end
                SEC_KEY: begin
                    if (w_idx_inc < r_kcount) begin
                        n_idx = w_idx_inc;
                    end else begin
                        n_idx = '0;
                        n_sec = (r_vcount != 9'd0) ? SEC_VAL : SEC_TERM;
                    end
                end
                SEC_VAL: begin
                    if (w_idx_inc < r_vcount) begin
                        n_idx = w_idx_inc;
                    end else begin
                        n_sec = SEC_TERM;
                    end
                end
                default: begin
                    n_sec = SEC_TERM;
                end
            endcase
        end else if (i_cmd.push) begin
            n_pack = '0;
            n_fill = '0;
        end
    end

    // Line number as shown on result items
    assign w_line_ext = 32'(r_line);
    assign w_shown    = (w_line_ext > 32'(SHOWN_MAX)) ? SHOWN_MAX : w_line_ext[15:0];
    assign w_out_free = !r_ov || i_out_ready;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kcount <= '0;
            r_kpend  <= '0;
            r_vcount <= '0;
            r_vpend  <= '0;
            r_ovf    <= '0;
            r_line   <= LINE_COUNT_BITS'(1);
            r_sec    <= SEC_KLEN;
            r_idx    <= '0;
            r_done   <= 1'b0;
            r_term   <= 1'b0;
            r_fill   <= '0;
            r_pack   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_kcount <= n_kcount;
            r_kpend  <= n_kpend;
            r_vcount <= n_vcount;
            r_vpend  <= n_vpend;
            r_ovf    <= n_ovf;
            r_line   <= n_line;
            r_sec    <= n_sec;
            r_idx    <= n_idx;
            r_done   <= n_done;
            r_term   <= n_term;
            r_fill   <= n_fill;
            r_pack   <= n_pack;
            if (i_cmd.one || i_cmd.push) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_one_status <= n_one_status;
        if (i_cmd.one) begin
            r_odata   <= (r_one_status == ST_OK) ? 128'(MAGIC_WORD) : '0;
            r_ocount  <= (r_one_status == ST_OK) ? MAGIC_BYTES : 5'd0;
            r_olast   <= 1'b1;
            r_ostatus <= r_one_status;
            r_oline   <= w_shown;
        end else if (i_cmd.push) begin
            r_odata   <= r_pack;
            r_ocount  <= r_fill;
            r_olast   <= r_done;
            r_ostatus <= ST_OK;
            r_oline   <= w_shown;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_data_low    = r_odata[63:0];
    assign o_data_high   = r_odata[127:64];
    assign o_byte_count  = r_ocount;
    assign o_last        = r_olast;
    assign o_status      = r_ostatus;
    assign o_line_number = r_oline;

    always_comb begin
        o_stat.ev       = w_ev;
        o_stat.out_free = w_out_free;
        o_stat.pk_last  = w_pk_last;
        o_stat.pk_full  = (r_fill == 5'(LANES - 1));
        o_stat.done     = r_done;
    end

endmodule

`default_nettype wire

/* sv/keyvalue_text_to_tlv_encoder_top.sv */
// Key/value text to length-prefixed record encoder, top level.
//
// Input channel i_in: one transaction per text item (kind 0 start, 1 text
// byte, 2 end, 3 ignored). Output channel o_out: result items of up to 16
// bytes, lane 0 in the low byte of data_low, with byte_count, last, status
// and line_number.
// Text bytes that do not end a line are taken one per cycle with no result.
// A start gives the 4-byte header item, a failing line one error item; each
// is loaded into the output register from state S_ONE once that register is free.
// A line end or end of text with a record reads the key and value stores
// out byte by byte, each byte through S_FETCH (registered RAM read) and then
// S_PACK (lane packing); each item of up to 16 bytes then leaves via S_PUSH.
// No new input is taken during that readout.
// After an error the block ignores everything but a start.
// Reset (synchronous, active low) returns to idle waiting for a start; the
// field stores are not cleared.
// A stalled receiver holds the output register; the readout waits for it,
// while text bytes keep being taken as long as they produce no result.
// Depends on kvt_pkg, kvt_in_if, kvt_out_if, kvt_ctrl, kvt_dp, kvt_ram.
`default_nettype none

module keyvalue_text_to_tlv_encoder_top
    import kvt_pkg::*;
#(
    parameter int MAX_FIELD_LEN   = 255,
    parameter int LINE_COUNT_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kvt_in_if.sink     i_in,
    kvt_out_if.source  o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // Sequencing
    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Parsing, storage and packing
    kvt_dp #(
        .MAX_FIELD_LEN   (MAX_FIELD_LEN),
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_kind        (i_in.kind),
        .i_text_byte   (i_in.text_byte),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_data_low    (o_out.data_low),
        .o_data_high   (o_out.data_high),
        .o_byte_count  (o_out.byte_count),
        .o_last        (o_out.last),
        .o_status      (o_out.status),
        .o_line_number (o_out.line_number)
    );

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for keyvalue_text_to_tlv_encoder_top.
// Drives text items through kvt_in_if, checks every result item on kvt_out_if
// against an in-bench record encoder; depends on kvt_pkg and both interfaces.
`timescale 1ns / 100ps

module testbench
    import kvt_pkg::*;
();

    localparam logic [1:0] KIND_UNUSED = 2'd3;   // ignored by the block
    localparam int         MAX_LEN     = 255;
    localparam int         KEY_F       = 0;
    localparam int         VAL_F       = 1;
    localparam int         RANDOM_ITEMS = 470;
    localparam int         DRAIN_CYCLES = 100;
    localparam int         CYCLE_LIMIT  = 30_000_000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       nogap;
    } t_text_item;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  cnt;
        logic        last;
        logic [2:0]  st;
        logic [15:0] line;
    } t_chunk;

    logic clk = 1'b0;
    logic rst_n;

    kvt_in_if  in_ch();
    kvt_out_if out_ch();

    keyvalue_text_to_tlv_encoder_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Encoder state mirrored in the bench
    t_phase      phase_q;
    logic [7:0]  fld_buf [2][256];
    int          fld_cnt [2];
    int          fld_pend [2];
    logic [1:0]  fld_ovf;          // bit 0 key, bit 1 value
    logic [15:0] line_no;
    logic [7:0]  rec_buf [0:515];

    t_chunk      results_due [$];
    t_text_item  text_items [$];

    int          mismatches = 0;
    int          cycles = 0;
    bit          in_fire = 1'b0;
    bit          cur_nogap = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          calm_left [2] = '{0, 0};

    // ------------------------------------------------------------------
    // Record encoder
    // ------------------------------------------------------------------
    task automatic clear_fields();
        fld_cnt  = '{0, 0};
        fld_pend = '{0, 0};
        fld_ovf  = 2'b00;
    endtask

    // Append one byte to a field; blanks wait as pending until a real char
    task automatic field_push(input int f, input logic [7:0] b);
        int pos;
        pos = fld_cnt[f] + fld_pend[f];
        if (b <= CH_BLANK_MAX) begin
            if (pos < MAX_LEN) begin
                fld_buf[f][pos] = b;
                fld_pend[f]++;
            end
        end else if (pos >= MAX_LEN) begin
            fld_ovf[f]  = 1'b1;
            fld_cnt[f]  = MAX_LEN + 1;
            fld_pend[f] = 0;
        end else begin
            fld_buf[f][pos] = b;
            fld_cnt[f]      = pos + 1;
            fld_pend[f]     = 0;
        end
    endtask

    // Split rec_buf[0..n-1] into 16-byte result items
    task automatic pack_bytes(input int n);
        int     p;
        int     c;
        t_chunk ch;
        p = 0;
        while (p < n) begin
            c  = (n - p > 16) ? 16 : n - p;
            ch = '0;
            for (int i = 0; i < c; i++) begin
                if (i < 8) ch.lo[8*i +: 8]     = rec_buf[p + i];
                else       ch.hi[8*(i-8) +: 8] = rec_buf[p + i];
            end
            p += c;
            ch.cnt  = 5'(c);
            ch.last = (p >= n);
            ch.st   = ST_OK;
            ch.line = line_no;
            results_due.push_back(ch);
        end
    endtask

    task automatic push_error(input logic [2:0] st);
        t_chunk ch;
        ch      = '0;
        ch.last = 1'b1;
        ch.st   = st;
        ch.line = line_no;
        results_due.push_back(ch);
    endtask

    // Close the pending line: status, or the record bytes in rec_buf
    task automatic close_line(output logic [2:0] st, output int n);
        n  = 0;
        st = ST_OK;
        case (phase_q)
            PH_LINE, PH_COMMENT: st = ST_OK;
            PH_KEY:              st = fld_ovf[0] ? ST_KEY_LONG : ST_NO_SEP;
            default: begin
                if (fld_cnt[KEY_F] == 0)  st = ST_EMPTY_KEY;
                else if (fld_ovf[0])      st = ST_KEY_LONG;
                else if (fld_ovf[1])      st = ST_VAL_LONG;
                else begin
                    rec_buf[0] = 8'(fld_cnt[KEY_F]);
                    rec_buf[1] = 8'(fld_cnt[VAL_F]);
                    for (int i = 0; i < fld_cnt[KEY_F]; i++)
                        rec_buf[2 + i] = fld_buf[KEY_F][i];
                    for (int i = 0; i < fld_cnt[VAL_F]; i++)
                        rec_buf[2 + fld_cnt[KEY_F] + i] = fld_buf[VAL_F][i];
                    n = 2 + fld_cnt[KEY_F] + fld_cnt[VAL_F];
                end
            end
        endcase
    endtask

    // Work out the result items caused by one accepted text item
    task automatic encode_text_item(input logic [1:0] kind, input logic [7:0] b);
        logic [2:0] st;
        int         n;
        bit         is_sep;
        is_sep = (b == CH_EQUAL) || (b == CH_COLON);
        if (kind == KIND_START) begin
            clear_fields();
            line_no = 16'd1;
            phase_q = PH_LINE;
            for (int i = 0; i < 4; i++) rec_buf[i] = MAGIC_WORD[8*i +: 8];
            pack_bytes(int'(MAGIC_BYTES));
        end else if (kind == KIND_END && phase_q != PH_IDLE) begin
            close_line(st, n);
            phase_q = PH_IDLE;
            if (st != ST_OK) push_error(st);
            else begin
                rec_buf[n] = 8'h00;
                pack_bytes(n + 1);
            end
        end else if (kind == KIND_BYTE && phase_q != PH_IDLE) begin
            if (b == CH_NEWLINE) begin
                close_line(st, n);
                if (st != ST_OK) begin
                    push_error(st);
                    phase_q = PH_IDLE;
                end else begin
                    if (n > 0) pack_bytes(n);
                    clear_fields();
                    phase_q = PH_LINE;
                    if (line_no != SHOWN_MAX) line_no++;
                end
            end else begin
                case (phase_q)
                    PH_LINE: begin
                        if (b > CH_BLANK_MAX) begin
                            if (b == CH_HASH) phase_q = PH_COMMENT;
                            else if (is_sep)  phase_q = PH_VLEAD;
                            else begin
                                field_push(KEY_F, b);
                                phase_q = PH_KEY;
                            end
                        end
                    end
                    PH_KEY: begin
                        if (is_sep) begin
                            fld_pend[KEY_F] = 0;
                            phase_q = PH_VLEAD;
                        end else begin
                            field_push(KEY_F, b);
                        end
                    end
                    PH_VLEAD: begin
                        if (b > CH_BLANK_MAX) begin
                            phase_q = PH_VALUE;
                            field_push(VAL_F, b);
                        end
                    end
                    PH_VALUE: field_push(VAL_F, b);
                    default: ;
                endcase
            end
        end
        // unused kind and anything while idle: no effect
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    task automatic check_result();
        t_chunk want;
        if (results_due.size() == 0) begin
            report_mismatch("result with nothing pending, byte_count",
                            64'(out_ch.byte_count), 64'(0));
        end else begin
            want = results_due.pop_front();
            if (out_ch.data_low !== want.lo)
                report_mismatch("data_low", out_ch.data_low, want.lo);
            if (out_ch.data_high !== want.hi)
                report_mismatch("data_high", out_ch.data_high, want.hi);
            if (out_ch.byte_count !== want.cnt)
                report_mismatch("byte_count", 64'(out_ch.byte_count), 64'(want.cnt));
            if (out_ch.last !== want.last)
                report_mismatch("last", 64'(out_ch.last), 64'(want.last));
            if (out_ch.status !== want.st)
                report_mismatch("status", 64'(out_ch.status), 64'(want.st));
            if (out_ch.line_number !== want.line)
                report_mismatch("line_number", 64'(out_ch.line_number), 64'(want.line));
        end
    endtask

    // Monitor: outputs first, then the input transaction of this edge
    always @(posedge clk) begin
        in_fire = 1'b0;
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready) check_result();
            if (in_ch.valid && in_ch.ready) begin
                encode_text_item(in_ch.kind, in_ch.text_byte);
                in_fire = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle timing: mostly short gaps, a few long, with calm stretches
    // ------------------------------------------------------------------
    function automatic int pick_gap(input int side);
        int r;
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left[side] = $urandom_range(20, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Driver: present queued items, hold valid until the transaction
    always @(negedge clk) begin : drive_text
        logic       v;
        t_text_item it;
        v = in_ch.valid;
        if (in_fire) begin
            v        = 1'b0;
            gap_left = cur_nogap ? 0 : pick_gap(0);
        end
        if (rst_n && !v) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (text_items.size() != 0) begin
                it = text_items.pop_front();
                in_ch.kind      <= it.kind;
                in_ch.text_byte <= it.ch;
                cur_nogap = it.nogap;
                v = 1'b1;
            end
        end
        in_ch.valid <= v;
    end

    // Receiver back-pressure
    always @(negedge clk) begin
        if (stall_left > 0) stall_left--;
        else if ($urandom_range(0, 3) == 0) stall_left = pick_gap(1);
        out_ch.ready <= (stall_left == 0);
    end

    // Cycle count and watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic add_item(input logic [1:0] kind, input logic [7:0] ch,
                            input logic nogap = 1'b0);
        t_text_item it;
        it.kind  = kind;
        it.ch    = ch;
        it.nogap = nogap;
        text_items.push_back(it);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_item(KIND_BYTE, s[i]);
    endtask

    function automatic logic [7:0] blank_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 32)); while (c == CH_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (c == CH_NEWLINE);
        return c;
    endfunction

    // Non-blank char; keys avoid separators, and '#' as first char
    function automatic logic [7:0] text_char(input bit key_start, input bit in_key);
        logic [7:0] c;
        do c = 8'($urandom_range(33, 255));
        while ((in_key && (c == CH_EQUAL || c == CH_COLON)) || (key_start && c == CH_HASH));
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        return $urandom_range(0, 1) ? CH_EQUAL : CH_COLON;
    endfunction

    task automatic add_blanks(input int n);
        repeat (n) add_item(KIND_BYTE, blank_char());
    endtask

    // len non-blank chars; sparse runs of blanks between them unless dense
    task automatic add_field(input int len, input bit is_key, input bit dense);
        for (int i = 0; i < len; i++) begin
            if (!dense && i > 0 && $urandom_range(0, 5) == 0)
                add_blanks($urandom_range(1, 2));
            add_item(KIND_BYTE, text_char(is_key && i == 0, is_key));
        end
    endtask

    task automatic add_record(input int klen, input int vlen, input bit dense,
                              input bit close);
        if (!dense) add_blanks($urandom_range(0, 2));
        add_field(klen, 1'b1, dense);
        if (!dense) add_blanks($urandom_range(0, 2));
        add_item(KIND_BYTE, sep_char());
        if (!dense) add_blanks($urandom_range(0, 2));
        add_field(vlen, 1'b0, dense);
        if (!dense) add_blanks($urandom_range(0, 2));
        if (close) add_item(KIND_BYTE, CH_NEWLINE);
    endtask

    // Empty key, key with no separator, or a lone separator
    task automatic add_bad_line(input bit close);
        case ($urandom_range(0, 2))
            0: begin
                add_blanks($urandom_range(0, 3));
                add_item(KIND_BYTE, sep_char());
                add_field($urandom_range(0, 5), 1'b0, 1'b0);
            end
            1: begin
                add_blanks($urandom_range(0, 2));
                add_field($urandom_range(1, 6), 1'b1, 1'b0);
                add_blanks($urandom_range(0, 2));
            end
            default: add_item(KIND_BYTE, sep_char());
        endcase
        if (close) add_item(KIND_BYTE, CH_NEWLINE);
    endtask

    function automatic int key_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    endfunction

    // One document: start, a few lines, and an ending of some sort
    task automatic add_document();
        int r;
        int lines;
        bit alive;
        if ($urandom_range(0, 4) == 0) begin
            add_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
            add_item(KIND_BYTE, 8'($urandom_range(0, 255)));
        end
        add_item(KIND_START, 8'($urandom_range(0, 255)));
        lines = $urandom_range(0, 6);
        alive = 1'b1;
        for (int l = 0; l < lines && alive; l++) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                add_record(key_len(), $urandom_range(0, 14), 1'b0, 1'b1);
            end else if (r < 60) begin
                add_record($urandom_range(1, 8), $urandom_range(16, 60), 1'b0, 1'b1);
            end else if (r < 70) begin
                add_blanks($urandom_range(0, 2));
                add_item(KIND_BYTE, CH_HASH);
                repeat ($urandom_range(0, 10)) add_item(KIND_BYTE, any_char());
                add_item(KIND_BYTE, CH_NEWLINE);
            end else if (r < 80) begin
                add_blanks($urandom_range(0, 3));
                add_item(KIND_BYTE, CH_NEWLINE);
            end else if (r < 85) begin
                add_item(KIND_UNUSED, 8'($urandom_range(0, 255)));
            end else if (r < 93) begin
                add_bad_line(1'b1);
                alive = 1'b0;
            end else begin
                repeat ($urandom_range(1, 12)) add_item(KIND_BYTE, any_char());
                add_item(KIND_BYTE, CH_NEWLINE);
                alive = 1'b0;
            end
        end
        r = $urandom_range(0, 9);
        if (!alive) begin
            // block may be idle after an error; then these are dropped
            if (r < 5) add_item(KIND_BYTE, 8'($urandom_range(0, 255)));
            if (r < 2) add_item(KIND_END, 8'($urandom_range(0, 255)));
        end else if (r < 3) begin
            add_record(key_len(), $urandom_range(0, 10), 1'b0, 1'b0);
            add_item(KIND_END, 8'($urandom_range(0, 255)));
        end else if (r < 4) begin
            add_bad_line(1'b0);
            add_item(KIND_END, 8'($urandom_range(0, 255)));
        end else if (r < 8) begin
            add_item(KIND_END, 8'($urandom_range(0, 255)));
        end else begin
            // left open; the next start restarts mid-line
            add_field($urandom_range(0, 3), 1'b1, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int base;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.kind      = KIND_START;
        in_ch.text_byte = 8'h00;
        out_ch.ready    = 1'b0;
        phase_q         = PH_IDLE;
        line_no         = 16'd1;
        clear_fields();

        // Directed: idle drops, header, comment, blank line, byte extremes,
        // unused kind, empty key and missing separator at end, empty value
        add_item(KIND_BYTE, "a");
        add_item(KIND_END, 8'h00);
        add_item(KIND_UNUSED, 8'hFF);
        add_item(KIND_START, 8'hFF);
        add_item(KIND_BYTE, 8'h09);
        add_text("#c\n");
        add_item(KIND_BYTE, 8'h20);
        add_item(KIND_BYTE, 8'h00);
        add_item(KIND_BYTE, CH_NEWLINE);
        add_item(KIND_BYTE, 8'h20);
        add_text("K!=");
        add_item(KIND_BYTE, 8'h00);
        add_item(KIND_BYTE, 8'hFF);
        add_item(KIND_BYTE, 8'h20);
        add_item(KIND_BYTE, CH_NEWLINE);
        add_item(KIND_UNUSED, 8'h00);
        add_text(":v");
        add_item(KIND_END, 8'h00);
        add_item(KIND_START, 8'h00);
        add_text("ab");
        add_item(KIND_END, 8'h00);
        add_item(KIND_START, 8'h00);
        add_text("k=");
        add_item(KIND_END, 8'h00);

        // Field length limits: full record, key and value one past the limit,
        // overflow through a kept blank, trailing blanks past a full field
        add_item(KIND_START, 8'h00);
        add_field(MAX_LEN, 1'b1, 1'b1);
        add_item(KIND_BYTE, CH_EQUAL);
        add_field(MAX_LEN, 1'b0, 1'b1);
        add_item(KIND_END, 8'h00);
        add_item(KIND_START, 8'h00);
        add_field(MAX_LEN + 1, 1'b1, 1'b1);
        add_item(KIND_BYTE, CH_COLON);
        add_text("v\n");
        add_item(KIND_START, 8'h00);
        add_field(MAX_LEN - 1, 1'b1, 1'b1);
        add_item(KIND_BYTE, 8'h20);
        add_text("x=v\n");
        add_item(KIND_START, 8'h00);
        add_text("k=");
        add_field(MAX_LEN + 1, 1'b0, 1'b1);
        add_item(KIND_BYTE, CH_NEWLINE);
        add_item(KIND_START, 8'h00);
        add_field(MAX_LEN + 1, 1'b1, 1'b1);
        add_item(KIND_BYTE, CH_NEWLINE);
        add_item(KIND_START, 8'h00);
        add_field(MAX_LEN, 1'b1, 1'b1);
        add_blanks(3);
        add_item(KIND_BYTE, sep_char());
        add_field(MAX_LEN, 1'b0, 1'b1);
        add_blanks(5);
        add_item(KIND_BYTE, CH_NEWLINE);
        add_item(KIND_END, 8'h00);

        // Blank lines back to back, then a record and an error
        add_item(KIND_START, 8'h00);
        repeat (20) add_item(KIND_BYTE, CH_NEWLINE, 1'b1);
        add_text("k=v\n");
        add_text("=\n");

        // Random documents
        base = text_items.size();
        while (text_items.size() < base + RANDOM_ITEMS) add_document();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (text_items.size() != 0 || in_ch.valid) @(posedge clk);
        while (results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
